// File: design/lap_tagged_ring_channel_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lap-tagged ring channel
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LAP_TAGGED_RING_CHANNEL_TOP_ASSERT_SVH
`define LAP_TAGGED_RING_CHANNEL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTRC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LTRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ltrc_pkg.sv
// ----------------------------------------------------------------------------
// ltrc_pkg
// Types, codes and default sizes shared by the lap-tagged ring channel.
// ----------------------------------------------------------------------------
package ltrc_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int DATA_WIDTH_DEFAULT = 32;

	localparam int LAP_W  = 32;
	localparam int CAP_W  = 5;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	localparam int WORD_W = 32;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	// Command codes; code 3 is ignored.
	localparam logic [CMD_W-1:0] CMD_SEND  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECV  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BLOCK  = 2'd1;
	localparam logic [STAT_W-1:0] ST_CLOSED = 2'd2;

	localparam logic [LAP_W-1:0] HEAD_LAP_RESET = 32'd1;
	localparam logic [LAP_W-1:0] LAP_WRAP_STEP  = 32'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [WORD_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] data_out;
	} rsp_t;

endpackage

// File: design/ltrc_ram.sv
// ----------------------------------------------------------------------------
// ltrc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ltrc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read word holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ltrc_engine.sv
// ----------------------------------------------------------------------------
// ltrc_engine
// Sequencer: clears the lap memory, then reads a slot, checks its lap and
// writes it back, keeping the head and tail pointers and the result register.
// ----------------------------------------------------------------------------
module ltrc_engine import ltrc_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEFAULT,
	parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
	parameter int AW         = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CAP_W-1:0]      capacity,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	output logic                  lap_we,
	output logic [AW-1:0]         lap_waddr,
	output logic [LAP_W-1:0]      lap_wdata,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  logic [LAP_W-1:0]      lap_rdata,
	output logic                  data_we,
	output logic [DATA_WIDTH-1:0] data_wdata,
	input  logic [DATA_WIDTH-1:0] data_rdata
);

	localparam int CW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     tail_pos_q;
	logic [AW-1:0]     head_pos_q;
	logic [LAP_W-1:0]  tail_lap_q;
	logic [LAP_W-1:0]  head_lap_q;
	logic              closed_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	cmd_t              cmd_s1;
	logic [AW-1:0]     addr_s1;

	logic              is_send;
	logic              is_recv;
	logic              lap_hit;
	logic              moves;
	logic              done;
	logic [LAP_W-1:0]  exp_lap;
	logic [CW-1:0]     cap_min;
	logic [CW-1:0]     cap_use;
	logic              wrap;
	logic [AW-1:0]     pos_next;
	rsp_t              rsp_d;

	assign cmd_ready = (state_q == S_IDLE);
	assign mem_re    = cmd_valid && cmd_ready;
	assign mem_raddr = (cmd.command == CMD_RECV) ? head_pos_q : tail_pos_q;

	assign is_send = (cmd_s1.command == CMD_SEND);
	assign is_recv = (cmd_s1.command == CMD_RECV);
	assign exp_lap = is_send ? tail_lap_q : head_lap_q;
	assign lap_hit = (lap_rdata == exp_lap);
	assign moves   = (is_send || is_recv) && !closed_q && lap_hit;
	assign done    = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);

	// Slots in use, clamped to one and to the built depth.
	assign cap_min = (capacity == '0) ? CW'(1) : CW'(capacity);
	assign cap_use = (cap_min > CW'(DEPTH)) ? CW'(DEPTH) : cap_min;
	assign wrap     = (CW'(addr_s1) + CW'(1)) >= cap_use;
	assign pos_next = wrap ? '0 : addr_s1 + AW'(1);

	always_comb begin
		rsp_d.status   = ST_OK;
		rsp_d.data_out = '0;
		if (is_send || is_recv) begin
			if (closed_q) begin
				rsp_d.status = ST_CLOSED;
			end else if (!lap_hit) begin
				rsp_d.status = ST_BLOCK;
			end else if (is_recv) begin
				rsp_d.data_out = WORD_W'(data_rdata);
			end
		end
	end

	assign lap_we     = (state_q == S_CLEAR) || (done && moves);
	assign lap_waddr  = (state_q == S_CLEAR) ? clr_q : addr_s1;
	assign lap_wdata  = (state_q == S_CLEAR) ? '0 : lap_rdata + LAP_W'(1);
	assign data_we    = done && moves && is_send;
	assign data_wdata = DATA_WIDTH'(cmd_s1.data_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			tail_pos_q  <= '0;
			head_pos_q  <= '0;
			tail_lap_q  <= '0;
			head_lap_q  <= HEAD_LAP_RESET;
			closed_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !done) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
						if (cmd_s1.command == CMD_CLOSE) begin
							closed_q <= 1'b1;
						end
						if (moves && is_send) begin
							tail_pos_q <= pos_next;
							if (wrap) begin
								tail_lap_q <= tail_lap_q + LAP_WRAP_STEP;
							end
						end
						if (moves && is_recv) begin
							head_pos_q <= pos_next;
							if (wrap) begin
								head_lap_q <= head_lap_q + LAP_WRAP_STEP;
							end
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (mem_re) begin
			cmd_s1  <= cmd;
			addr_s1 <= mem_raddr;
		end
		if (done) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/lap_tagged_ring_channel_top.sv
// ----------------------------------------------------------------------------
// lap_tagged_ring_channel_top
// Bounded ring-buffer channel whose slots carry a lap tag; takes send,
// receive and close commands and answers each with one status word.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+---------------------------
//  cmd     | in        | cmd_valid / cmd_ready     | cmd_t: command, data_in
//  rsp     | out       | rsp_valid / rsp_ready     | rsp_t: status, data_out
//  cfg     | in        | cfg_we, no back-pressure  | capacity (5 bits)
//
// Each command first reads the slot's lap and data from the slot memories,
// then checks the lap, writes the slot back and loads the result register.
// That read-then-write-back of each slot sets the rate, and it also keeps a
// following command from seeing a stale slot. After reset a clearing pass
// zeroes the lap memory, with cmd_ready held low. A waiting result does not
// stop the next command from being taken; that command then holds in its
// check and write-back step until the result register is free.
//
module lap_tagged_ring_channel_top import ltrc_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEFAULT,
	parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	// Slot index width; a single-slot ring still uses a one-bit index.
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CAP_W-1:0]      capacity_q;
	logic                  lap_we;
	logic [AW-1:0]         lap_waddr;
	logic [LAP_W-1:0]      lap_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [LAP_W-1:0]      lap_rdata;
	logic                  data_we;
	logic [DATA_WIDTH-1:0] data_wdata;
	logic [DATA_WIDTH-1:0] data_rdata;

	// The capacity register is written as it stands; clamping to the range
	// of slots in use happens where the pointers advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Lap tags: cleared after reset by the engine's sweep.
	ltrc_ram #(
		.WIDTH (LAP_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_lap_ram (
		.clk   (clk),
		.we    (lap_we),
		.waddr (lap_waddr),
		.wdata (lap_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (lap_rdata)
	);

	// Slot data: never cleared, since a slot is only received after a send
	// has written it and raised its lap to match the head.
	ltrc_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (lap_waddr),
		.wdata (data_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (data_rdata)
	);

	ltrc_engine #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (capacity_q),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.lap_we     (lap_we),
		.lap_waddr  (lap_waddr),
		.lap_wdata  (lap_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.lap_rdata  (lap_rdata),
		.data_we    (data_we),
		.data_wdata (data_wdata),
		.data_rdata (data_rdata)
	);

endmodule

// File: design/ltrc_checker.sv
// ----------------------------------------------------------------------------
// ltrc_checker
// Port-level checks on the channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lap_tagged_ring_channel_top_assert.svh"

module ltrc_checker import ltrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A result word stays put until it is taken.
	`LTRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp moved")

	// Only a successful receive carries data.
	`LTRC_ASSERT_SAME(a_nonok_zero, rsp_valid && rsp.status != ST_OK, rsp.data_out == '0, "data")

	// No command is taken while the one before it is in its slot write-back.
	`LTRC_ASSERT_NEXT(a_no_back_to_back, cmd_valid && cmd_ready, !cmd_ready, "cmd in write-back")

	// A fresh result follows a taken command, through its slot read and write-back state.
	`LTRC_ASSERT_SAME(a_rsp_follows_cmd, $rose(rsp_valid), $past(cmd_valid && cmd_ready, 2), "no cmd")

endmodule

bind lap_tagged_ring_channel_top ltrc_checker u_ltrc_checker (.*);
